// ===== hdl/svf_pkg.sv =====
// svf_pkg: shared constants and controller/datapath command type for the
// state-variable filter. No dependencies.
package svf_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS       = 17;
    localparam int FRAC_BITS       = 16;
    localparam int INTEG_BITS      = 19;
    localparam int INTEG_LIMIT     = 200000;
    localparam int MODE_BITS       = 2;
    localparam int APB_ADDR_BITS   = 2;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_FILTER_MODE = 2'd0;

    localparam logic [MODE_BITS-1:0] MODE_LOW  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BAND = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_HIGH = 2'd2;

    typedef struct packed {
        logic load;
        logic step_high;
        logic step_band;
        logic step_low;
        logic commit;
    } dp_cmd_t;

endpackage

// ===== hdl/svf_dp.sv =====
// svf_dp: filter datapath with one shared multiplier, integrators and
// output register. Depends on svf_pkg; driven by svf_ctrl commands.
module svf_dp #(
    parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  svf_pkg::dp_cmd_t                    cmd,
    input  logic [svf_pkg::MODE_BITS-1:0]       mode,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic [svf_pkg::COEF_BITS-1:0]       cutoff_coef,
    input  logic [svf_pkg::COEF_BITS-1:0]       resonance_coef,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    localparam int DW = ((SAMPLE_BITS > 20) ? SAMPLE_BITS : 20) + 5;
    localparam int PW = DW + svf_pkg::COEF_BITS + 1;

    localparam logic signed [DW-1:0] SMAX = {{(DW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {{(DW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [DW-1:0] LIM_HI = DW'(svf_pkg::INTEG_LIMIT);
    localparam logic signed [DW-1:0] LIM_LO = -LIM_HI;

    logic signed [SAMPLE_BITS-1:0]          x_reg;
    logic [svf_pkg::COEF_BITS-1:0]          cut_reg;
    logic [svf_pkg::COEF_BITS-1:0]          res_reg;
    logic signed [DW-1:0]                   high_reg, high_next;
    logic signed [DW-1:0]                   band_new_reg, band_new_next;
    logic signed [DW-1:0]                   low_new_reg, low_new_next;
    logic signed [svf_pkg::INTEG_BITS-1:0]  low_reg, low_next;
    logic signed [svf_pkg::INTEG_BITS-1:0]  band_reg, band_next;
    logic signed [SAMPLE_BITS-1:0]          out_reg, out_next;

    logic signed [DW-1:0]                   mul_a;
    logic [svf_pkg::COEF_BITS-1:0]          mul_b;
    logic signed [PW-1:0]                   prod;
    logic signed [DW-1:0]                   scaled;
    logic signed [DW-1:0]                   sel;

    // shared multiplier, floor Q16 scaling
    always_comb
    begin
        if (cmd.step_high)
        begin
            mul_a = DW'(band_reg);
            mul_b = res_reg;
        end
        else if (cmd.step_band)
        begin
            mul_a = high_reg;
            mul_b = cut_reg;
        end
        else
        begin
            mul_a = band_new_reg;
            mul_b = cut_reg;
        end
        prod   = PW'(mul_a) * PW'($signed({1'b0, mul_b}));
        scaled = DW'(prod >>> svf_pkg::FRAC_BITS);
    end

    always_comb
    begin
        high_next     = high_reg;
        band_new_next = band_new_reg;
        low_new_next  = low_new_reg;
        low_next      = low_reg;
        band_next     = band_reg;
        out_next      = out_reg;

        case (mode)
            svf_pkg::MODE_HIGH: sel = high_reg;
            svf_pkg::MODE_BAND: sel = band_new_reg;
            default:            sel = low_new_reg;
        endcase

        if (cmd.step_high)
            high_next = DW'(x_reg) - DW'(low_reg) - scaled;
        if (cmd.step_band)
            band_new_next = DW'(band_reg) + scaled;
        if (cmd.step_low)
            low_new_next = DW'(low_reg) + scaled;

        if (cmd.commit)
        begin
            if (sel > SMAX)
                out_next = SAMPLE_BITS'(SMAX);
            else if (sel < SMIN)
                out_next = SAMPLE_BITS'(SMIN);
            else
                out_next = SAMPLE_BITS'(sel);

            if (low_new_reg > LIM_HI)
                low_next = svf_pkg::INTEG_BITS'(LIM_HI);
            else if (low_new_reg < LIM_LO)
                low_next = svf_pkg::INTEG_BITS'(LIM_LO);
            else
                low_next = svf_pkg::INTEG_BITS'(low_new_reg);

            if (band_new_reg > LIM_HI)
                band_next = svf_pkg::INTEG_BITS'(LIM_HI);
            else if (band_new_reg < LIM_LO)
                band_next = svf_pkg::INTEG_BITS'(LIM_LO);
            else
                band_next = svf_pkg::INTEG_BITS'(band_new_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            band_reg <= '0;
        end
        else
        begin
            low_reg  <= low_next;
            band_reg <= band_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample_in;
            cut_reg <= cutoff_coef;
            res_reg <= resonance_coef;
        end
        high_reg     <= high_next;
        band_new_reg <= band_new_next;
        low_new_reg  <= low_new_next;
        out_reg      <= out_next;
    end

    assign sample_out = out_reg;

endmodule

// ===== hdl/svf_ctrl.sv =====
// svf_ctrl: sequencer for the three multiply steps and the output
// handshake. Depends on svf_pkg; commands svf_dp.
module svf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output svf_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIGH,
        ST_BAND,
        ST_LOW,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_commit;
    logic   accept;

    assign can_commit = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_COMMIT) && can_commit);
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        cmd.load      = accept;
        cmd.step_high = (state_reg == ST_HIGH);
        cmd.step_band = (state_reg == ST_BAND);
        cmd.step_low  = (state_reg == ST_LOW);
        cmd.commit    = (state_reg == ST_COMMIT) && can_commit;

        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_HIGH;
            end
            ST_HIGH:  state_next = ST_BAND;
            ST_BAND:  state_next = ST_LOW;
            ST_LOW:   state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (can_commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = accept ? ST_HIGH : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/state_variable_filter.sv =====
// state_variable_filter: Chamberlin state-variable filter, Q16 coefficients,
// with the mode register on an APB-style port. Uses svf_pkg, svf_ctrl, svf_dp.
//
// For each sample request, a single shared multiplier runs the three
// dependent products (band*resonance, high*cutoff, new band*cutoff) one per
// cycle, and a commit step then selects and clips the output and clamps the
// integrators to +/-200000. The commit step waits until the output
// register is free or being read; the next request can be accepted in
// that step. filter_mode picks low (0, and 3), band (1) or high (2);
// write it only while the filter is idle.
module state_variable_filter #(
    parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [svf_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [svf_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [svf_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    input  logic [svf_pkg::COEF_BITS-1:0]        cutoff_coef,
    input  logic [svf_pkg::COEF_BITS-1:0]        resonance_coef,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_BITS-1:0]        sample_out
);

    logic [svf_pkg::MODE_BITS-1:0] mode_reg, mode_next;
    svf_pkg::dp_cmd_t              cmd;

    assign pready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && (paddr == svf_pkg::ADDR_FILTER_MODE))
            mode_next = pwdata[svf_pkg::MODE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= svf_pkg::MODE_LOW;
        else
            mode_reg <= mode_next;
    end

    always_comb
    begin
        if (paddr == svf_pkg::ADDR_FILTER_MODE)
            prdata = {{(svf_pkg::APB_DATA_BITS-svf_pkg::MODE_BITS){1'b0}}, mode_reg};
        else
            prdata = '0;
    end

    svf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    svf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode_reg),
        .sample_in      (sample_in),
        .cutoff_coef    (cutoff_coef),
        .resonance_coef (resonance_coef),
        .sample_out     (sample_out)
    );

endmodule
